>>> hw/rtl/lgre_pkg.sv
// Shared constants, types and the B3/S23 rule for the Life raster engine.
package lgre_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int CFG_W    = 11;
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int WID_W    = $clog2(MAX_WIDTH + 1);
	localparam int HGT_W    = $clog2(MAX_HEIGHT + 1);
	localparam int ROW_W    = $clog2(MAX_HEIGHT + 2);
	localparam int CNT_W    = 20;
	localparam int AREA_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;
	localparam int RESET_SIZE = 64;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 2);

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic CMD_CELL  = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	localparam logic [1:0] NS_DEAD = 2'd0;
	localparam logic [1:0] NS_BORN = 2'd1;
	localparam logic [1:0] NS_SURV = 2'd2;

	// one accepted word as it enters the line buffer / window stage
	typedef struct packed {
		logic             valid;
		logic             row_end_emit;  // result for the last cell of the previous row
		logic             inner_emit;    // result from the updated window
		logic             mem_op;        // line buffer read/write and window shift
		logic             restart;       // frame complete, clear the window
		logic             first_col;
		logic             mask_above;
		logic             mask_mid;
		logic             alive;
		logic             frame_last;
		logic [COL_W-1:0] addr;
	} pipe_t;

	// line buffer write port; data[0] row above, data[1] middle row
	typedef struct packed {
		logic             en;
		logic [COL_W-1:0] addr;
		logic [1:0]       data;
	} wr_t;

	typedef struct packed {
		logic [1:0] next_state;
		logic       frame_last;
	} res_t;

	function automatic logic [WID_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
		logic [WID_W-1:0] r;
		if (v < CFG_W'(2)) begin
			r = WID_W'(2);
		end else if (32'(v) > 32'(MAX_WIDTH)) begin
			r = WID_W'(MAX_WIDTH);
		end else begin
			r = WID_W'(v);
		end
		return r;
	endfunction

	function automatic logic [HGT_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
		logic [HGT_W-1:0] r;
		if (v < CFG_W'(2)) begin
			r = HGT_W'(2);
		end else if (32'(v) > 32'(MAX_HEIGHT)) begin
			r = HGT_W'(MAX_HEIGHT);
		end else begin
			r = HGT_W'(v);
		end
		return r;
	endfunction

	// window bit 3*k+r: column k (0 oldest), row r (0 above, 2 newest); bit 4 is the center
	function automatic logic [1:0] life_rule(input logic [8:0] win);
		logic [3:0] cnt;
		logic [1:0] ns;
		cnt = 4'd0;
		for (int k = 0; k < 9; k++) begin
			if (k != 4) begin
				cnt = cnt + 4'(win[k]);
			end
		end
		if (win[4]) begin
			ns = (cnt == 4'd2 || cnt == 4'd3) ? NS_SURV : NS_DEAD;
		end else begin
			ns = (cnt == 4'd3) ? NS_BORN : NS_DEAD;
		end
		return ns;
	endfunction

endpackage

>>> hw/rtl/lgre_line_ram.sv
// Combined two-row line buffer: registered synchronous read, one write port.
module lgre_line_ram
	import lgre_pkg::*;
(
	input  logic             clk,
	input  logic             rd_en,
	input  logic [COL_W-1:0] rd_addr,
	output logic [1:0]       rd_data,
	input  wr_t              wr
);

	logic [1:0] mem [MAX_WIDTH];
	logic [1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hw/rtl/lgre_ctrl.sv
// Raster position tracking, result counting and line buffer read issue.
module lgre_ctrl
	import lgre_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              command,
	input  logic              cell_alive,
	input  logic              cfg_restart,
	input  logic [WID_W-1:0]  grid_w,
	input  logic [HGT_W-1:0]  grid_h,
	input  logic [AREA_W-1:0] area_last,
	output pipe_t             pipe_s1,
	output logic              rd_en,
	output logic [COL_W-1:0]  rd_addr
);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [CNT_W-1:0] emitted_q;

	logic [COL_W-1:0] c;
	logic [WID_W-1:0] c_inc;
	logic             wrap;
	logic             in_grid, ignore, alive, row_end, restart, mem_op, inner, emit, last;

	always_comb begin
		c       = (WID_W'(col_q) >= grid_w) ? '0 : col_q;
		in_grid = row_q < ROW_W'(grid_h);
		ignore  = in_grid && (command == CMD_DRAIN);
		alive   = in_grid && cell_alive;
		row_end = (c == '0) && (row_q >= ROW_W'(2));
		restart = row_end && (row_q >= ROW_W'(grid_h) + ROW_W'(1));
		mem_op  = !ignore && !restart;
		inner   = mem_op && (c != '0) && (row_q >= ROW_W'(1));
		emit    = !ignore && (row_end || inner);
		last    = 32'(emitted_q) == 32'(area_last);
		c_inc   = WID_W'(c) + WID_W'(1);
		wrap    = c_inc >= grid_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			emitted_q <= '0;
		end else if (cfg_restart) begin
			col_q     <= '0;
			row_q     <= '0;
			emitted_q <= '0;
		end else if (accept && !ignore) begin
			if (restart) begin
				col_q     <= '0;
				row_q     <= '0;
				emitted_q <= '0;
			end else begin
				col_q     <= wrap ? '0 : c_inc[COL_W-1:0];
				row_q     <= wrap ? row_q + ROW_W'(1) : row_q;
				emitted_q <= emitted_q + CNT_W'(emit);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_s1 <= '0;
		end else begin
			pipe_s1.valid        <= accept && !ignore;
			pipe_s1.row_end_emit <= row_end;
			pipe_s1.inner_emit   <= inner;
			pipe_s1.mem_op       <= mem_op;
			pipe_s1.restart      <= restart;
			pipe_s1.first_col    <= c == '0;
			pipe_s1.mask_above   <= row_q >= ROW_W'(2);
			pipe_s1.mask_mid     <= row_q >= ROW_W'(1);
			pipe_s1.alive        <= alive;
			pipe_s1.frame_last   <= last;
			pipe_s1.addr         <= c;
		end
	end

	assign rd_en   = accept && mem_op;
	assign rd_addr = c;

endmodule

>>> hw/rtl/lgre_window.sv
// 3x3 neighbour window, line buffer write-back and rule evaluation.
module lgre_window
	import lgre_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_restart,
	input  pipe_t      pipe_s1,
	input  logic [1:0] rd_data,
	output wr_t        wr,
	output logic       push,
	output res_t       push_res
);

	logic [8:0] win_q;
	logic [8:0] win_next, win_shift;
	logic [2:0] newcol;

	always_comb begin
		newcol    = {pipe_s1.alive, rd_data[1] & pipe_s1.mask_mid,
		             rd_data[0] & pipe_s1.mask_above};
		win_shift = {3'b000, win_q[8:3]};
		win_next  = pipe_s1.first_col ? {newcol, 6'b000000} : {newcol, win_q[8:3]};
		push_res.next_state = pipe_s1.row_end_emit ? life_rule(win_shift) : life_rule(win_next);
		push_res.frame_last = pipe_s1.frame_last;
		push      = pipe_s1.valid && (pipe_s1.row_end_emit || pipe_s1.inner_emit);
		wr.en     = pipe_s1.valid && pipe_s1.mem_op;
		wr.addr   = pipe_s1.addr;
		// middle row moves up unmasked; new cell becomes the middle row
		wr.data   = {pipe_s1.alive, rd_data[1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (cfg_restart) begin
			win_q <= '0;
		end else if (pipe_s1.valid) begin
			if (pipe_s1.restart) begin
				win_q <= '0;
			end else if (pipe_s1.mem_op) begin
				win_q <= win_next;
			end
		end
	end

endmodule

>>> hw/rtl/lgre_outq.sv
// Small result queue that decouples the pipeline from receiver stalls.
module lgre_outq
	import lgre_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  res_t                push_res,
	input  logic                out_stall,
	output logic                out_valid,
	output res_t                out_res,
	output logic [OQ_CNT_W-1:0] count
);

	res_t                entry_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OQ_CNT_W-1:0] count_q;
	logic                pop;

	assign out_valid = count_q != '0;
	assign pop       = out_valid && !out_stall;
	assign out_res   = entry_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OQ_PTR_W'(1);
			end
			count_q <= count_q + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
		end
	end

endmodule

>>> hw/rtl/life_generation_raster_engine_core.sv
// Top level of the Conway Life (B3/S23) raster generation engine.
//
// Cells of one generation enter in raster order on the cell channel
// (cell_valid/cell_stall, command, cell_alive), one word per cycle while not stalled. The
// result channel (result_valid/result_stall, next_state, frame_last) gives
// the next state of each cell: dead, newly born or survived. The result for
// cell n is caused by the input word at position n + grid_width + 1; after
// the last row, drain words (or further cells, taken as dead) flush the rest.
// The word that yields the last cell ends the frame; the next starts anew.
// A word accepted into the pipeline register pushes its result into the result
// queue; the registered queue count then makes it valid to the receiver.
// One word per clock while cell_stall is low. The line buffer has one read
// and one write port: it is read on accept and written back the cycle after;
// the same column is never touched by two words in flight, so no forwarding.
// Reset: grid 64x64, positions cleared; the line buffer is not cleared,
// rows not yet written in a frame are masked as dead. No clearing pass.
// A register write over APB restarts the frame; write only while idle.
// A stalled receiver fills a 4-word result queue; cell_stall rises when the
// queue plus the word in flight could no longer be absorbed.
module life_generation_raster_engine_core
	import lgre_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// cell channel
	input  logic              cell_valid,
	output logic              cell_stall,
	input  logic              command,
	input  logic              cell_alive,
	// result channel
	output logic              result_valid,
	input  logic              result_stall,
	output logic [1:0]        next_state,
	output logic              frame_last,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [CFG_W-1:0]    width_q, height_q;
	logic [AREA_W-1:0]   area_last_q;
	logic                cfg_wr;
	logic                accept;
	pipe_t               pipe_s1;
	logic                rd_en;
	logic [COL_W-1:0]    rd_addr;
	logic [1:0]          rd_data;
	wr_t                 wr;
	logic                push;
	res_t                push_res, out_res;
	logic [OQ_CNT_W-1:0] oq_count;

	// ---- register file ----
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[2])
			REG_WIDTH:  prdata = DATA_W'(width_q);
			REG_HEIGHT: prdata = DATA_W'(height_q);
			default:    prdata = '0;
		endcase
	end

	// area - 1 is kept precomputed so the last-cell compare is a plain equality
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= CFG_W'(RESET_SIZE);
			height_q    <= CFG_W'(RESET_SIZE);
			area_last_q <= AREA_W'(AREA_W'(clamp_width(CFG_W'(RESET_SIZE)))
			               * AREA_W'(clamp_height(CFG_W'(RESET_SIZE))) - AREA_W'(1));
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_WIDTH: begin
					width_q     <= pwdata[CFG_W-1:0];
					area_last_q <= AREA_W'(AREA_W'(clamp_width(pwdata[CFG_W-1:0]))
					               * AREA_W'(clamp_height(height_q)) - AREA_W'(1));
				end
				REG_HEIGHT: begin
					height_q    <= pwdata[CFG_W-1:0];
					area_last_q <= AREA_W'(AREA_W'(clamp_width(width_q))
					               * AREA_W'(clamp_height(pwdata[CFG_W-1:0])) - AREA_W'(1));
				end
				default: begin
					width_q <= width_q;
				end
			endcase
		end
	end

	// ---- flow control: stall only when the queue could overflow ----
	assign cell_stall = (oq_count + OQ_CNT_W'(pipe_s1.valid)) >= OQ_CNT_W'(OQ_DEPTH);
	assign accept     = cell_valid && !cell_stall;

	lgre_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.command     (command),
		.cell_alive  (cell_alive),
		.cfg_restart (cfg_wr),
		.grid_w      (clamp_width(width_q)),
		.grid_h      (clamp_height(height_q)),
		.area_last   (area_last_q),
		.pipe_s1     (pipe_s1),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr)
	);

	lgre_line_ram u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr      (wr)
	);

	lgre_window u_win (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_restart (cfg_wr),
		.pipe_s1     (pipe_s1),
		.rd_data     (rd_data),
		.wr          (wr),
		.push        (push),
		.push_res    (push_res)
	);

	lgre_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_res  (push_res),
		.out_stall (result_stall),
		.out_valid (result_valid),
		.out_res   (out_res),
		.count     (oq_count)
	);

	assign next_state = out_res.next_state;
	assign frame_last = out_res.frame_last;

endmodule

>>> hw/rtl/lgre_checker.sv
// Port-level checks for the Life raster engine, bound to the top level.
module lgre_checker
	import lgre_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       cell_valid,
	input logic       cell_stall,
	input logic       result_valid,
	input logic       result_stall,
	input logic [1:0] next_state,
	input logic       frame_last
);

	// a stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(next_state)
		&& $stable(frame_last))
		else $error("result word changed under stall");

	a_state_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (next_state == NS_DEAD || next_state == NS_BORN
		|| next_state == NS_SURV))
		else $error("next_state out of range");

	// nothing pending and nothing taken last cycle: the input is open
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!result_valid) && $past(!(cell_valid && !cell_stall)) |-> !cell_stall)
		else $error("cell channel stalled while idle");

	// a new result traces back through the pipeline register and the queue count to an accepted word
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(cell_valid && !cell_stall, 2))
		else $error("result without an accepted word");

endmodule

bind life_generation_raster_engine_core lgre_checker u_lgre_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cell_valid   (cell_valid),
	.cell_stall   (cell_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.next_state   (next_state),
	.frame_last   (frame_last)
);

>>> dv/tb_life_generation_raster_engine_core.sv
// Self-checking testbench for the Life raster generation engine core.
`timescale 1ns / 1ps

module tb_life_generation_raster_engine_core;
	import lgre_pkg::*;

	localparam int LIMIT_CYCLES = 1_000_000;
	// quiet cycles after the last result before a register write or the end;
	// covers the result latency plus words in flight that yield nothing
	localparam int SETTLE_CYCLES = 8;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              cell_valid   = 1'b0;
	logic              cell_stall;
	logic              command      = CMD_CELL;
	logic              cell_alive   = 1'b0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic [1:0]        next_state;
	logic              frame_last;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [ADDR_W-1:0] paddr        = '0;
	logic [DATA_W-1:0] pwdata       = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// predictor state: two line buffers, the 3x3 window, raster position
	logic [MAX_WIDTH-1:0] row_up_bits;   // row above the middle row
	logic [MAX_WIDTH-1:0] row_mid_bits;  // row above the incoming one
	logic [8:0]           nb_window;     // bit 3*col+row, col 0 oldest, row 2 newest
	int unsigned          in_col;
	int unsigned          in_row;
	logic [CNT_W-1:0]     cells_emitted;
	logic [CFG_W-1:0]     width_reg;
	logic [CFG_W-1:0]     height_reg;

	res_t        next_gen_q[$];     // next states still owed by the block
	int unsigned live_words    = 0; // accepted words that were not ignored
	int          mismatches    = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int unsigned hold_left     = 0; // long receiver hold-off, in cycles
	int unsigned cycle_count   = 0;

	life_generation_raster_engine_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cell_valid   (cell_valid),
		.cell_stall   (cell_stall),
		.command      (command),
		.cell_alive   (cell_alive),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.next_state   (next_state),
		.frame_last   (frame_last),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// size register as the block uses it: clamped to [2, top]
	function automatic int unsigned eff_size(input logic [CFG_W-1:0] v, input int unsigned top);
		if (v < 2) return 2;
		if (v > top) return top;
		return 32'(v);
	endfunction

	// B3/S23 on a 3x3 window; bit 4 is the center cell
	function automatic logic [1:0] b3s23(input logic [8:0] nb);
		int unsigned n;
		n = $countones(nb & 9'h1EF);
		if (nb[4]) return (n == 2 || n == 3) ? NS_SURV : NS_DEAD;
		return (n == 3) ? NS_BORN : NS_DEAD;
	endfunction

	function automatic void clear_frame();
		nb_window     = '0;
		in_col        = 0;
		in_row        = 0;
		cells_emitted = '0;
	endfunction

	function automatic void reset_model();
		row_up_bits  = '0;
		row_mid_bits = '0;
		width_reg    = CFG_W'(RESET_SIZE);
		height_reg   = CFG_W'(RESET_SIZE);
		clear_frame();
	endfunction

	function automatic void push_next_gen(input logic [8:0] nb, input int unsigned area);
		res_t e;
		e.next_state = b3s23(nb);
		e.frame_last = (32'(cells_emitted) == area - 1);
		next_gen_q.push_back(e);
		cells_emitted = cells_emitted + CNT_W'(1);
	endfunction

	// advance the model by one accepted word, queueing any next state it yields
	function automatic void predict_generation(input logic cmd, input logic alive);
		int unsigned w, h, c, r, area;
		logic v, up, mid;
		w    = eff_size(width_reg, MAX_WIDTH);
		h    = eff_size(height_reg, MAX_HEIGHT);
		area = w * h;
		v    = alive;
		c    = (in_col >= w) ? 0 : in_col;
		r    = in_row;
		if (r < h) begin
			if (cmd == CMD_DRAIN) return;   // drain inside the grid: no effect
		end else begin
			v = 1'b0;                       // below the grid everything is dead
		end
		live_words++;
		// first column: the window still holds the last cell of the previous row
		if (c == 0 && r >= 2) begin
			push_next_gen(nb_window >> 3, area);
			if (r >= h + 1) begin
				clear_frame();              // last cell out, next word starts a frame
				return;
			end
		end
		up  = (r >= 2) ? row_up_bits[COL_W'(c)] : 1'b0;
		mid = (r >= 1) ? row_mid_bits[COL_W'(c)] : 1'b0;
		row_up_bits[COL_W'(c)]  = row_mid_bits[COL_W'(c)];
		row_mid_bits[COL_W'(c)] = v;
		if (c == 0) begin
			nb_window = {v, mid, up, 6'b0};
		end else begin
			nb_window = {v, mid, up, nb_window[8:3]};
			if (r >= 1) push_next_gen(nb_window, area);
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
		end
		in_col = c;
		in_row = r;
	endfunction

	// ------------------------------------------------------------------
	// Result side: random stall plus an optional long hold-off
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left    <= hold_left - 1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin : check_next_gen
		res_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (next_gen_q.size() == 0) begin
				$display("%0t: unexpected word: expected none, actual next_state %0d frame_last %0d",
					$time, next_state, frame_last);
				mismatches++;
			end else begin
				want = next_gen_q.pop_front();
				if (next_state !== want.next_state) begin
					$display("%0t: next_state expected %0d actual %0d",
						$time, want.next_state, next_state);
					mismatches++;
				end
				if (frame_last !== want.frame_last) begin
					$display("%0t: frame_last expected %0d actual %0d",
						$time, want.frame_last, frame_last);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// 0: no idling, 1: sender gaps, 2: receiver stalls, 3: both
	function automatic void set_idle_mode(input int mode);
		case (mode)
			1: begin
				send_idle_pct  = 54;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct  = 0;
				recv_stall_pct = 54;
			end
			3: begin
				send_idle_pct  = 34;
				recv_stall_pct = 34;
			end
			default: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
		endcase
	endfunction

	function automatic int unsigned pick_density();
		if ($urandom_range(7) == 0) return $urandom_range(1) ? 100 : 0;
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CFG_W-1:0] pick_size();
		if ($urandom_range(9) == 0) return CFG_W'($urandom_range(1));  // clamps up to 2
		return CFG_W'($urandom_range(2, 9));
	endfunction

	// offer one word and hold it until taken; idle gaps carry junk payload
	task automatic send_word(input logic cmd, input logic alive);
		while ($urandom_range(99) < send_idle_pct) begin
			cell_valid <= 1'b0;
			command    <= 1'($urandom());
			cell_alive <= 1'($urandom());
			@(posedge clk);
		end
		cell_valid <= 1'b1;
		command    <= cmd;
		cell_alive <= alive;
		@(posedge clk);
		while (cell_stall) @(posedge clk);
		predict_generation(cmd, alive);
	endtask

	// stop offering, let every owed word arrive and the pipe go quiet
	task automatic wait_idle();
		cell_valid <= 1'b0;
		while (next_gen_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup phase, access phase, then the bus is released
	task automatic write_grid_reg(input logic sel, input logic [CFG_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= {(DATA_W-CFG_W)'($urandom()), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (sel == REG_WIDTH) width_reg = value;
		else height_reg = value;
		clear_frame();
		@(posedge clk);
	endtask

	// one frame from position 0: grid cells with stray drains, then the
	// flush of w+1 words mixing drains and (dead-taken) cells; cut > 0
	// stops early after that many counted words
	task automatic send_frame(input int unsigned density, input int unsigned cut);
		int unsigned w, h, n, total;
		w     = eff_size(width_reg, MAX_WIDTH);
		h     = eff_size(height_reg, MAX_HEIGHT);
		total = w * (h + 1) + 1;
		n     = 0;
		while (n < total && (cut == 0 || n < cut)) begin
			if (n < w * h) begin
				if ($urandom_range(99) < 6) send_word(CMD_DRAIN, 1'($urandom()));
				send_word(CMD_CELL, $urandom_range(99) < density);
			end else begin
				send_word(1'($urandom()), 1'($urandom()));
			end
			n++;
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// reset grid size (64x64): a partial frame with stray drains and sender gaps
	task automatic test_reset_size();
		set_idle_mode(1);
		repeat (100) begin
			if ($urandom_range(19) == 0) send_word(CMD_DRAIN, 1'($urandom()));
			else send_word(CMD_CELL, $urandom_range(99) < 40);
		end
	endtask

	// 3x2 grid: warm-up, a drain inside the grid, birth and survival,
	// flush with drains and a live cell taken as dead; then an all-alive frame
	task automatic test_directed();
		wait_idle();
		set_idle_mode(0);
		write_grid_reg(REG_WIDTH, CFG_W'(3));
		write_grid_reg(REG_HEIGHT, CFG_W'(2));
		send_word(CMD_CELL, 1'b1);
		send_word(CMD_DRAIN, 1'b1);    // ignored
		send_word(CMD_CELL, 1'b1);
		send_word(CMD_CELL, 1'b0);
		send_word(CMD_CELL, 1'b1);
		send_word(CMD_CELL, 1'b0);     // dead with three neighbours: born
		send_word(CMD_CELL, 1'b0);
		send_word(CMD_DRAIN, 1'b0);    // flush starts
		send_word(CMD_CELL, 1'b1);     // below the grid: dead
		send_word(CMD_DRAIN, 1'b1);
		send_word(CMD_CELL, 1'b0);     // yields the last cell, frame ends
		repeat (10) send_word(CMD_CELL, 1'b1);
	endtask

	// clamped and extreme sizes; the smallest grid runs full frames,
	// the large ones are cut short
	task automatic test_size_extremes();
		logic [CFG_W-1:0] widths[5]  = '{11'd0, 11'd1024, 11'd2, 11'd2047, 11'd1};
		logic [CFG_W-1:0] heights[5] = '{11'd1, 11'd2, 11'd2047, 11'd0, 11'd1024};
		int unsigned      cuts[5]    = '{0, 100, 60, 40, 30};
		for (int i = 0; i < 5; i++) begin
			wait_idle();
			set_idle_mode(i % 4);
			write_grid_reg(REG_WIDTH, widths[i]);
			write_grid_reg(REG_HEIGHT, heights[i]);
			repeat ((i == 0) ? 3 : 1) send_frame(pick_density(), cuts[i]);
		end
	endtask

	// receiver holds off while the sender keeps pushing: queue fills, input stalls
	task automatic test_backpressure();
		wait_idle();
		write_grid_reg(REG_WIDTH, CFG_W'(5));
		write_grid_reg(REG_HEIGHT, CFG_W'(3));
		set_idle_mode(0);
		hold_left <= 400;
		repeat (3) send_frame(35, 0);
	endtask

	// random small frames, back to back or after fresh sizes; some broken off
	task automatic test_random_frames();
		int unsigned start, frames, cut, w, h;
		logic        must_write;
		start      = live_words;
		frames     = 0;
		must_write = 1'b1;
		while (live_words - start < 200) begin
			set_idle_mode(frames % 4);
			if (must_write || $urandom_range(2) == 0) begin
				wait_idle();
				write_grid_reg(REG_WIDTH, pick_size());
				write_grid_reg(REG_HEIGHT, pick_size());
			end
			w   = eff_size(width_reg, MAX_WIDTH);
			h   = eff_size(height_reg, MAX_HEIGHT);
			cut = ($urandom_range(7) == 0) ? $urandom_range(1, w * (h + 1)) : 0;
			send_frame(pick_density(), cut);
			must_write = (cut != 0);
			frames++;
		end
	endtask

	initial begin
		reset_model();
		set_idle_mode(0);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_size();
		test_directed();
		test_size_extremes();
		test_backpressure();
		test_random_frames();
		wait_idle();
		if (mismatches == 0) begin
			$display("life_generation_raster_engine_core: match");
		end else begin
			$display("life_generation_raster_engine_core: mismatch");
		end
		$finish;
	end

	// watchdog
	initial begin
		while (cycle_count < LIMIT_CYCLES) @(posedge clk);
		$display("life_generation_raster_engine_core: mismatch");
		$finish;
	end

endmodule

>>> life_generation_raster_engine_core.f
hw/rtl/lgre_pkg.sv
hw/rtl/lgre_line_ram.sv
hw/rtl/lgre_ctrl.sv
hw/rtl/lgre_window.sv
hw/rtl/lgre_outq.sv
hw/rtl/life_generation_raster_engine_core.sv
hw/rtl/lgre_checker.sv
dv/tb_life_generation_raster_engine_core.sv
